// File: sv/plist_pkg.sv
// Shared types and constants for the positional list engine.
`default_nettype none
package plist_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 8;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int ITEM_W   = 8;
  localparam int STATUS_W = 2;
  localparam int ELEM_W   = 8;
  localparam int OCC_W    = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_POP_FRONT  = 3'd1,
    MODE_INSERT_AT  = 3'd2,
    MODE_REMOVE_AT  = 3'd3,
    MODE_PUSH_BACK  = 3'd4,
    MODE_DUMP       = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_INSERT,
    SH_REMOVE,
    SH_ROTATE
  } shift_op_t;

  typedef enum logic {
    ST_ACCEPT,
    ST_DUMP
  } ctrl_state_t;

endpackage
`default_nettype wire

// File: sv/plist_req_if.sv
// Request channel: operation, position and value with valid/ready.
`default_nettype none
interface plist_req_if
  import plist_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  position;
  logic [ITEM_W-1:0] item_value;

  modport source (output valid, output mode, output position, output item_value,
                  input ready);
  modport sink (input valid, input mode, input position, input item_value,
                output ready);
endinterface
`default_nettype wire

// File: sv/plist_rsp_if.sv
// Result channel: status, element, occupancy and last with valid/ready.
`default_nettype none
interface plist_rsp_if
  import plist_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ELEM_W-1:0]   element;
  logic [OCC_W-1:0]    occupancy;
  logic                last;

  modport source (output valid, output status, output element, output occupancy,
                  output last, input ready);
  modport sink (input valid, input status, input element, input occupancy,
                input last, output ready);
endinterface
`default_nettype wire

// File: sv/plist_cell.sv
// One storage cell of the list chain, shifting to or from its neighbors.
`default_nettype none
module plist_cell
  import plist_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int INDEX      = 0
) (
  input  wire                            clk,
  input  shift_op_t                      op,
  input  wire [$clog2(CAPACITY+1)-1:0]   pos,
  input  wire [$clog2(CAPACITY+1)-1:0]   cnt,
  input  wire [DATA_WIDTH-1:0]           new_value,
  input  wire [DATA_WIDTH-1:0]           left,
  input  wire [DATA_WIDTH-1:0]           right,
  input  wire [DATA_WIDTH-1:0]           first,
  output logic [DATA_WIDTH-1:0]          value
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] K   = CW'(INDEX);
  localparam logic [CW-1:0] KP1 = CW'(INDEX + 1);

  logic [DATA_WIDTH-1:0] data;
  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    unique case (op)
      SH_INSERT: begin
        priority if (K == pos) begin
          data_next = new_value;
        end else if (K > pos && K <= cnt) begin
          data_next = left;
        end else begin
          data_next = data;
        end
      end
      SH_REMOVE: begin
        if (K >= pos && KP1 < cnt) begin
          data_next = right;
        end
      end
      SH_ROTATE: begin
        priority if (KP1 < cnt) begin
          data_next = right;
        end else if (KP1 == cnt) begin
          data_next = first;
        end else begin
          data_next = data;
        end
      end
      SH_HOLD: begin
        data_next = data;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign value = data;

endmodule
`default_nettype wire

// File: sv/plist_ctrl.sv
// Request decode, count tracking, dump sequencing and the result register.
`default_nettype none
module plist_ctrl
  import plist_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire                            clk,
  input  wire                            rst,
  plist_req_if.sink                      req,
  plist_rsp_if.source                    rsp,
  input  wire [DATA_WIDTH-1:0]           head,
  output shift_op_t                      op,
  output logic [$clog2(CAPACITY+1)-1:0]  shift_pos,
  output logic [$clog2(CAPACITY+1)-1:0]  cnt,
  output logic [DATA_WIDTH-1:0]          new_value
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = (CW > POS_W) ? CW : POS_W;
  localparam int OW  = (CW > OCC_W) ? CW : OCC_W;
  localparam int EW  = (DATA_WIDTH > ELEM_W) ? DATA_WIDTH : ELEM_W;
  localparam int IVW = (DATA_WIDTH > ITEM_W) ? DATA_WIDTH : ITEM_W;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  ctrl_state_t       state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     dump_idx, dump_idx_next;
  logic              rsp_valid, rsp_valid_next;
  status_t           status_q, status_next;
  logic [ELEM_W-1:0] element_q, element_next;
  logic [OCC_W-1:0]  occ_q, occ_next;
  logic              last_q, last_next;

  logic              slot_free;
  logic [PW-1:0]     pos_w;
  logic [PW-1:0]     count_w;
  logic [OW-1:0]     occ_w;
  logic [EW-1:0]     head_w;
  logic [IVW-1:0]    item_w;
  logic              dump_last;

  assign slot_free = !rsp_valid || rsp.ready;
  assign pos_w     = PW'(req.position);
  assign count_w   = PW'(count);
  assign head_w    = EW'(head);
  assign item_w    = IVW'(req.item_value);
  assign new_value = item_w[DATA_WIDTH-1:0];
  assign cnt       = count;
  assign dump_last = (dump_idx + CW'(1)) == count;

  always_comb begin
    state_next     = state;
    count_next     = count;
    dump_idx_next  = dump_idx;
    rsp_valid_next = rsp_valid && !rsp.ready;
    status_next    = status_q;
    element_next   = element_q;
    occ_next       = occ_q;
    last_next      = last_q;
    op             = SH_HOLD;
    shift_pos      = '0;
    req.ready      = 1'b0;
    occ_w          = '0;
    unique case (state)
      ST_ACCEPT: begin
        req.ready = slot_free;
        if (req.valid && slot_free) begin
          rsp_valid_next = 1'b1;
          status_next    = STAT_OK;
          element_next   = '0;
          last_next      = 1'b1;
          unique case (mode_t'(req.mode))
            MODE_PUSH_FRONT: begin
              if (count == CAP) begin
                status_next = STAT_FULL;
              end else begin
                op         = SH_INSERT;
                count_next = count + CW'(1);
              end
            end
            MODE_POP_FRONT: begin
              if (count == '0) begin
                status_next = STAT_EMPTY;
              end else begin
                op         = SH_REMOVE;
                count_next = count - CW'(1);
              end
            end
            MODE_INSERT_AT: begin
              priority if (pos_w > count_w) begin
                status_next = STAT_RANGE;
              end else if (count == CAP) begin
                status_next = STAT_FULL;
              end else begin
                op         = SH_INSERT;
                shift_pos  = pos_w[CW-1:0];
                count_next = count + CW'(1);
              end
            end
            MODE_REMOVE_AT: begin
              if (pos_w >= count_w) begin
                status_next = STAT_RANGE;
              end else begin
                op         = SH_REMOVE;
                shift_pos  = pos_w[CW-1:0];
                count_next = count - CW'(1);
              end
            end
            MODE_PUSH_BACK: begin
              if (count == CAP) begin
                status_next = STAT_FULL;
              end else begin
                op         = SH_INSERT;
                shift_pos  = count;
                count_next = count + CW'(1);
              end
            end
            MODE_DUMP: begin
              if (count == '0) begin
                status_next = STAT_EMPTY;
              end else begin
                rsp_valid_next = rsp_valid && !rsp.ready;
                status_next    = status_q;
                element_next   = element_q;
                last_next      = last_q;
                dump_idx_next  = '0;
                state_next     = ST_DUMP;
              end
            end
            MODE_CLEAR: begin
              count_next = '0;
            end
            default: begin
              count_next = count;
            end
          endcase
          if (state_next == ST_ACCEPT) begin
            occ_w    = OW'(count_next);
            occ_next = occ_w[OCC_W-1:0];
          end
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          rsp_valid_next = 1'b1;
          status_next    = STAT_OK;
          element_next   = head_w[ELEM_W-1:0];
          occ_w          = OW'(count);
          occ_next       = occ_w[OCC_W-1:0];
          last_next      = dump_last;
          op             = SH_ROTATE;
          dump_idx_next  = dump_idx + CW'(1);
          if (dump_last) begin
            state_next = ST_ACCEPT;
          end
        end
      end
      default: begin
        state_next = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCEPT;
      count     <= '0;
      dump_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dump_idx  <= dump_idx_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    status_q  <= status_next;
    element_q <= element_next;
    occ_q     <= occ_next;
    last_q    <= last_next;
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = status_q;
  assign rsp.element   = element_q;
  assign rsp.occupancy = occ_q;
  assign rsp.last      = last_q;

endmodule
`default_nettype wire

// File: sv/positional_list_engine_core.sv
// Positional list engine: a chain of value cells under a request controller.
//
// Holds an ordered list of up to CAPACITY values in a row of cells that shift
// toward the back on insert and toward the front on remove, all cells together.
// For edit requests (push, pop, insert, remove, clear) the result appears in
// the output register on the next cycle, and a new request is taken every
// cycle as long as results are taken. A dump of n elements rotates the cell
// chain once per element: it streams n results at one per cycle while results
// are taken and holds off requests until its last result is loaded. Cells need
// no clearing after reset; only cells below the count are ever read.
`default_nettype none
module positional_list_engine_core
  import plist_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire           clk,
  input  wire           rst,
  plist_req_if.sink     req,
  plist_rsp_if.source   rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  shift_op_t             op;
  logic [CW-1:0]         shift_pos;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH-1:0] new_value;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  plist_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .head      (cell_q[0]),
    .op        (op),
    .shift_pos (shift_pos),
    .cnt       (cnt),
    .new_value (new_value)
  );

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam int L = (k == 0) ? 0 : k - 1;
    localparam int R = (k == CAPACITY - 1) ? k : k + 1;

    plist_cell #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (k)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .pos       (shift_pos),
      .cnt       (cnt),
      .new_value (new_value),
      .left      (cell_q[L]),
      .right     (cell_q[R]),
      .first     (cell_q[0]),
      .value     (cell_q[k])
    );
  end

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Testbench for the positional list engine: directed and random list edits and dumps checked against a list predictor.
`timescale 1ns / 100ps
module testbench;
  import plist_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NOP = 3'd7;
  localparam int RANDOM_REQUESTS = 450;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PRESSURE_AFTER  = 120;
  localparam int PRESSURE_CYCLES = 150;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [ITEM_W-1:0] item_value;
  } list_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ELEM_W-1:0]   element;
    logic [OCC_W-1:0]    occupancy;
    logic                last;
  } list_rsp_t;

  logic clk;
  logic rst;

  plist_req_if req ();
  plist_rsp_if rsp ();

  positional_list_engine_core uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  list_req_t         pending_requests[$];
  list_rsp_t         expected_results[$];
  logic [ITEM_W-1:0] list_contents[$];
  int                planned_count;
  int                mismatch_count;
  int                results_seen;
  int                burst_left;
  int                gap_left;
  int                stall_pct;
  int                pattern_left;
  int                hold_left;
  bit                pressure_done;
  int                idle_cycles;

  always #10 clk = ~clk;

  function automatic void push_result(logic [STATUS_W-1:0] st, logic [ELEM_W-1:0] elem,
                                      int occ, logic fin);
    list_rsp_t r;
    r.status    = st;
    r.element   = elem;
    r.occupancy = occ[OCC_W-1:0];
    r.last      = fin;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_list_op(logic [MODE_W-1:0] op, logic [POS_W-1:0] idx,
                                          logic [ITEM_W-1:0] v);
    logic [STATUS_W-1:0] st;
    int                  n;
    st = STAT_OK;
    n  = list_contents.size();
    if (op == MODE_DUMP) begin
      if (n == 0) begin
        push_result(STAT_EMPTY, '0, 0, 1'b1);
      end else begin
        for (int i = 0; i < n; i++)
          push_result(STAT_OK, list_contents[i], n, i == n - 1);
      end
    end else begin
      case (op)
        MODE_PUSH_FRONT: begin
          if (n >= DEF_CAPACITY) st = STAT_FULL;
          else list_contents.push_front(v);
        end
        MODE_POP_FRONT: begin
          if (n == 0) st = STAT_EMPTY;
          else void'(list_contents.pop_front());
        end
        MODE_INSERT_AT: begin
          if (idx > n) st = STAT_RANGE;
          else if (n >= DEF_CAPACITY) st = STAT_FULL;
          else list_contents.insert(idx, v);
        end
        MODE_REMOVE_AT: begin
          if (idx >= n) st = STAT_RANGE;
          else list_contents.delete(idx);
        end
        MODE_PUSH_BACK: begin
          if (n >= DEF_CAPACITY) st = STAT_FULL;
          else list_contents.push_back(v);
        end
        MODE_CLEAR: list_contents.delete();
        default: ;
      endcase
      push_result(st, '0, list_contents.size(), 1'b1);
    end
  endfunction

  function automatic void queue_request(logic [MODE_W-1:0] op, logic [POS_W-1:0] idx,
                                        logic [ITEM_W-1:0] v);
    list_req_t r;
    r.mode       = op;
    r.position   = idx;
    r.item_value = v;
    pending_requests.push_back(r);
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: if (planned_count < DEF_CAPACITY) planned_count++;
      MODE_POP_FRONT: if (planned_count > 0) planned_count--;
      MODE_INSERT_AT: if (idx <= planned_count && planned_count < DEF_CAPACITY) planned_count++;
      MODE_REMOVE_AT: if (idx < planned_count) planned_count--;
      MODE_CLEAR: planned_count = 0;
      default: ;
    endcase
  endfunction

  function automatic void queue_growth();
    case ($urandom_range(0, 2))
      0: queue_request(MODE_PUSH_FRONT, $urandom_range(0, 31), $urandom_range(0, 255));
      1: queue_request(MODE_PUSH_BACK, $urandom_range(0, 31), $urandom_range(0, 255));
      default: queue_request(MODE_INSERT_AT, $urandom_range(0, planned_count),
                             $urandom_range(0, 255));
    endcase
  endfunction

  function automatic void queue_shrink();
    if ($urandom_range(0, 1) == 0)
      queue_request(MODE_POP_FRONT, $urandom_range(0, 31), $urandom_range(0, 255));
    else
      queue_request(MODE_REMOVE_AT, $urandom_range(0, planned_count - 1), $urandom_range(0, 255));
  endfunction

  function automatic void queue_edit();
    if (planned_count == 0 || $urandom_range(0, 9) < 6) queue_growth();
    else queue_shrink();
  endfunction

  function automatic void queue_dump();
    queue_request(MODE_DUMP, $urandom_range(0, 31), $urandom_range(0, 255));
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : drive_requests
    list_req_t next_req;
    logic      offer;
    if (rst) begin
      req.valid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (req.valid && req.ready)
        predict_list_op(req.mode, req.position, req.item_value);
      if (!req.valid || req.ready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          req.mode       <= next_req.mode;
          req.position   <= next_req.position;
          req.item_value <= next_req.item_value;
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        req.valid <= offer;
      end
    end
  end

  always @(posedge clk) begin : collect_results
    list_rsp_t want;
    logic      ready_next;
    if (rst) begin
      rsp.ready     <= 1'b0;
      stall_pct     = 0;
      pattern_left  = 0;
      hold_left     = 0;
      pressure_done = 1'b0;
      results_seen  = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d element %0d occupancy %0d last %0d",
                   $time, rsp.status, rsp.element, rsp.occupancy, rsp.last);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("element", want.element, rsp.element);
          check_field("occupancy", want.occupancy, rsp.occupancy);
          check_field("last", want.last, rsp.last);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        hold_left     = PRESSURE_CYCLES;
        ready_next    = 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(8, 64);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        pattern_left--;
        ready_next = ($urandom_range(0, 99) >= stall_pct);
      end
      rsp.ready <= ready_next;
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int directed_total;
    clk            = 1'b0;
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.mode       = '0;
    req.position   = '0;
    req.item_value = '0;
    rsp.ready      = 1'b0;
    idle_cycles    = 0;
    mismatch_count = 0;
    planned_count  = 0;

    queue_request(MODE_DUMP, 5'd0, 8'h00);
    queue_request(MODE_POP_FRONT, 5'd0, 8'h00);
    queue_request(MODE_REMOVE_AT, 5'd0, 8'h00);
    queue_request(MODE_INSERT_AT, 5'd1, 8'h33);
    queue_request(MODE_NOP, 5'd0, 8'h00);
    queue_request(MODE_CLEAR, 5'd0, 8'h00);
    queue_request(MODE_INSERT_AT, 5'd0, 8'h00);
    queue_request(MODE_PUSH_FRONT, 5'd0, 8'hFF);
    queue_request(MODE_PUSH_BACK, 5'd0, 8'hAA);
    queue_request(MODE_INSERT_AT, 5'd3, 8'h55);
    queue_request(MODE_INSERT_AT, 5'd2, 8'h0F);
    queue_request(MODE_REMOVE_AT, 5'd31, 8'hFF);
    queue_request(MODE_INSERT_AT, 5'd31, 8'hFF);
    queue_request(MODE_REMOVE_AT, 5'd5, 8'h00);
    queue_request(MODE_INSERT_AT, 5'd6, 8'h77);
    queue_request(MODE_DUMP, 5'd0, 8'h00);
    queue_request(MODE_NOP, 5'd31, 8'hFF);
    queue_request(MODE_REMOVE_AT, 5'd4, 8'h00);
    queue_request(MODE_REMOVE_AT, 5'd0, 8'h00);
    queue_request(MODE_POP_FRONT, 5'd0, 8'h00);
    queue_request(MODE_DUMP, 5'd0, 8'h00);
    queue_request(MODE_CLEAR, 5'd0, 8'h00);
    queue_request(MODE_DUMP, 5'd0, 8'h00);
    directed_total = pending_requests.size();

    while (pending_requests.size() < directed_total + RANDOM_REQUESTS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          while (planned_count < DEF_CAPACITY) queue_growth();
          queue_request(MODE_PUSH_FRONT, $urandom_range(0, 31), $urandom_range(0, 255));
          queue_request(MODE_PUSH_BACK, $urandom_range(0, 31), $urandom_range(0, 255));
          queue_request(MODE_INSERT_AT, $urandom_range(0, planned_count), $urandom_range(0, 255));
          queue_request(MODE_INSERT_AT, planned_count + 1, $urandom_range(0, 255));
          queue_dump();
        end
        2, 3, 4, 5: begin
          repeat ($urandom_range(4, 16)) queue_edit();
          if ($urandom_range(0, 1) == 0) queue_dump();
        end
        6: begin
          while (planned_count > 0) queue_shrink();
          queue_request(MODE_POP_FRONT, $urandom_range(0, 31), $urandom_range(0, 255));
          queue_request(MODE_REMOVE_AT, $urandom_range(0, 31), $urandom_range(0, 255));
          queue_dump();
        end
        7: begin
          repeat ($urandom_range(2, 8))
            queue_request($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 255));
        end
        8: begin
          queue_request(MODE_CLEAR, $urandom_range(0, 31), $urandom_range(0, 255));
          queue_dump();
        end
        default: begin
          queue_request(MODE_REMOVE_AT, planned_count, $urandom_range(0, 255));
          queue_request(MODE_INSERT_AT, planned_count + 1, $urandom_range(0, 255));
          queue_request(MODE_INSERT_AT, planned_count, $urandom_range(0, 255));
          if (planned_count > 0)
            queue_request(MODE_REMOVE_AT, planned_count - 1, $urandom_range(0, 255));
        end
      endcase
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (pending_requests.size() > 0 || req.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
